/* rtl/tnes_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnes_pkg
// Shared types and constants of the note event scheduler: field widths,
// reset values, operation and register codes, controller/datapath bundles.
// ----------------------------------------------------------------------------
package tnes_pkg;

  localparam int EVENTS_PER_BANK_DEF = 16;
  localparam int PENDING_SLOTS_DEF   = 16;
  localparam int PAYLOAD_BITS_DEF    = 32;

  localparam int OP_W      = 2;
  localparam int CYCLE_W   = 24;
  localparam int STEP_W    = 16;
  localparam int TIME_W    = 24;
  localparam int ELAPSED_W = 25;
  localparam int REM_W     = 25;
  localparam int VALUE_W   = 32;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 24;

  localparam logic [CYCLE_W-1:0] CYCLE_LEN_RST = 24'd1000000;
  localparam logic [STEP_W-1:0]  TICK_STEP_RST = 16'd320;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_SWAP  = 2'd1,
    OP_TICK  = 2'd2,
    OP_FLUSH = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CYCLE_LEN = 1'b0,
    CFG_TICK_STEP = 1'b1
  } cfg_idx_e;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic scan_ev;
    logic rank_step;
    logic emit;
    logic finish;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_due;
    logic rank_last;
    logic emit_hit;
  } sts_t;

endpackage

/* rtl/tnes_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnes_ctrl
// Sequencer of the scheduler: takes requests, steps the datapath through
// the bank scan, pending ranking, off emission and the closing update.
// ----------------------------------------------------------------------------
module tnes_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  input  logic [tnes_pkg::OP_W-1:0] op_i,
  input  tnes_pkg::sts_t            sts_i,
  output logic                      busy,
  output tnes_pkg::cmd_t            cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_SCAN_RD = 6'b000010,
    ST_SCAN_EV = 6'b000100,
    ST_RANK    = 6'b001000,
    ST_EMIT    = 6'b010000,
    ST_FINISH  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign accept = start && (state_q == ST_IDLE);
  assign busy   = (state_q != ST_IDLE);

  always_comb begin
    cmd_o           = '0;
    cmd_o.accept    = accept;
    cmd_o.scan_ev   = (state_q == ST_SCAN_EV);
    cmd_o.rank_step = (state_q == ST_RANK);
    cmd_o.emit      = (state_q == ST_EMIT);
    cmd_o.finish    = (state_q == ST_FINISH);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (tnes_pkg::op_e'(op_i))
            tnes_pkg::OP_TICK:  state_d = ST_SCAN_RD;
            tnes_pkg::OP_FLUSH: state_d = ST_RANK;
            default:            state_d = ST_IDLE;
          endcase
        end
      end
      ST_SCAN_RD: state_d = ST_SCAN_EV;
      ST_SCAN_EV: begin
        if (!sts_i.scan_due) state_d = ST_RANK;
      end
      ST_RANK: begin
        if (sts_i.rank_last) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!sts_i.emit_hit) state_d = ST_FINISH;
      end
      ST_FINISH: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/tnes_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnes_datapath
// Event banks, timekeeping, pending-off slots with rank counters, and the
// result register that holds one result back to mark the last one.
// ----------------------------------------------------------------------------
module tnes_datapath #(
  parameter int EVENTS_PER_BANK = tnes_pkg::EVENTS_PER_BANK_DEF,
  parameter int PENDING_SLOTS   = tnes_pkg::PENDING_SLOTS_DEF,
  parameter int PAYLOAD_BITS    = tnes_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tnes_pkg::cmd_t                 cmd_i,
  output tnes_pkg::sts_t                 sts_o,
  input  logic [tnes_pkg::OP_W-1:0]      op_i,
  input  logic [tnes_pkg::TIME_W-1:0]    event_start_i,
  input  logic [tnes_pkg::TIME_W-1:0]    event_length_i,
  input  logic [tnes_pkg::VALUE_W-1:0]   event_value_i,
  input  logic                           cfg_valid_i,
  input  logic [tnes_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [tnes_pkg::CFG_DAT_W-1:0] cfg_data_i,
  output logic                           result_valid_o,
  output logic [tnes_pkg::VALUE_W-1:0]   out_value_o,
  output logic                           is_on_o,
  output logic                           off_lost_o,
  output logic                           last_o
);

  localparam int CW    = $clog2(EVENTS_PER_BANK + 1);
  localparam int IW    = (EVENTS_PER_BANK > 1) ? $clog2(EVENTS_PER_BANK) : 1;
  localparam int AW    = $clog2(2 * EVENTS_PER_BANK);
  localparam int DEPTH = 2 * EVENTS_PER_BANK;
  localparam int SW    = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1;
  localparam int KW    = $clog2(PENDING_SLOTS + 1);
  localparam int VW    = (PAYLOAD_BITS < tnes_pkg::VALUE_W) ? PAYLOAD_BITS
                                                            : tnes_pkg::VALUE_W;
  localparam int TW    = tnes_pkg::TIME_W;
  localparam int EW    = tnes_pkg::ELAPSED_W;
  localparam int RW    = tnes_pkg::REM_W;

  // configuration
  logic [tnes_pkg::CYCLE_W-1:0] cycle_len_q;
  logic [tnes_pkg::STEP_W-1:0]  tick_step_q;

  // bank control
  logic          bank_sel_q;
  logic [CW-1:0] back_cnt_q, front_cnt_q, next_idx_q;
  logic [EW-1:0] elapsed_q;
  logic          is_tick_q;

  // event banks
  logic [TW-1:0] bank_start_mem [DEPTH];
  logic [TW-1:0] bank_len_mem   [DEPTH];
  logic [VW-1:0] bank_val_mem   [DEPTH];
  logic [TW-1:0] rd_start_q, rd_len_q;
  logic [VW-1:0] rd_val_q;

  // pending-off slots
  logic [VW-1:0]        pend_val_q [PENDING_SLOTS];
  logic signed [RW-1:0] pend_rem_q [PENDING_SLOTS];
  logic [PENDING_SLOTS-1:0] pend_vld_q;
  logic [SW-1:0]        rank_q [PENDING_SLOTS];
  logic [SW-1:0]        j_q;
  logic [KW-1:0]        k_q;

  // result path
  logic          hold_vld_q, hold_on_q, hold_lost_q;
  logic [VW-1:0] hold_val_q;
  logic          res_vld_q, out_on_q, out_lost_q, out_last_q;
  logic [tnes_pkg::VALUE_W-1:0] out_val_q;

  // combinational
  logic                 load_we;
  logic [AW-1:0]        wr_addr, rd_addr, base_rd, base_wr;
  logic [CW-1:0]        rd_cnt;
  logic                 in_range, due;
  logic                 free_any;
  logic [SW-1:0]        free_idx;
  logic                 alloc, lost;
  logic [PENDING_SLOTS-1:0] elig, ahead;
  logic signed [RW-1:0] rem_j;
  logic                 hit_any;
  logic [SW-1:0]        hit_idx;
  logic                 gen_vld, gen_on, gen_lost;
  logic [VW-1:0]        gen_val;
  logic [EW:0]          el_sum;
  logic [EW-1:0]        el_next;
  logic                 wrap;

  assign load_we = cmd_i.accept && (tnes_pkg::op_e'(op_i) == tnes_pkg::OP_LOAD)
                   && (back_cnt_q < CW'(EVENTS_PER_BANK));

  assign base_wr = bank_sel_q ? '0 : AW'(EVENTS_PER_BANK);
  assign base_rd = bank_sel_q ? AW'(EVENTS_PER_BANK) : '0;
  assign wr_addr = base_wr + AW'(back_cnt_q[IW-1:0]);

  assign in_range = (next_idx_q < front_cnt_q);
  assign due      = in_range && (elapsed_q >= EW'(rd_start_q));

  // one bank entry per cycle: read ahead when the current event fires
  assign rd_cnt  = (cmd_i.scan_ev && due) ? next_idx_q + CW'(1) : next_idx_q;
  assign rd_addr = base_rd + AW'(rd_cnt[IW-1:0]);

  // lowest free slot
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = PENDING_SLOTS - 1; i >= 0; i--) begin
      if (!pend_vld_q[i]) begin
        free_any = 1'b1;
        free_idx = SW'(i);
      end
    end
  end

  assign lost  = (rd_len_q != '0) && !free_any;
  assign alloc = cmd_i.scan_ev && due && (rd_len_q != '0) && free_any;

  // slots taking part in the ordered pass, and rank comparisons against slot j
  assign rem_j = pend_rem_q[j_q];

  always_comb begin
    for (int i = 0; i < PENDING_SLOTS; i++) begin
      elig[i] = pend_vld_q[i] &&
                (!is_tick_q || pend_rem_q[i][RW-1] || (pend_rem_q[i] == '0));
    end
    for (int i = 0; i < PENDING_SLOTS; i++) begin
      ahead[i] = elig[j_q] &&
                 ((rem_j < pend_rem_q[i]) ||
                  ((rem_j == pend_rem_q[i]) && (j_q < SW'(i))));
    end
  end

  always_comb begin
    hit_any = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < PENDING_SLOTS; i++) begin
      if (elig[i] && (KW'(rank_q[i]) == k_q)) begin
        hit_any = 1'b1;
        hit_idx = SW'(i);
      end
    end
  end

  always_comb begin
    gen_vld  = 1'b0;
    gen_on   = 1'b0;
    gen_lost = 1'b0;
    gen_val  = rd_val_q;
    if (cmd_i.scan_ev && due) begin
      gen_vld  = 1'b1;
      gen_on   = 1'b1;
      gen_lost = lost;
    end else if (cmd_i.emit && hit_any) begin
      gen_vld = 1'b1;
      gen_val = pend_val_q[hit_idx];
    end
  end

  assign sts_o.scan_due  = due;
  assign sts_o.rank_last = (j_q == SW'(PENDING_SLOTS - 1));
  assign sts_o.emit_hit  = hit_any;

  // elapsed time saturates at its full range
  assign el_sum  = {1'b0, elapsed_q} + (EW + 1)'(tick_step_q);
  assign el_next = el_sum[EW] ? '1 : el_sum[EW-1:0];
  assign wrap    = (elapsed_q >= EW'(cycle_len_q));

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cycle_len_q <= tnes_pkg::CYCLE_LEN_RST;
      tick_step_q <= tnes_pkg::TICK_STEP_RST;
      bank_sel_q  <= 1'b0;
      back_cnt_q  <= '0;
      front_cnt_q <= '0;
      next_idx_q  <= '0;
      elapsed_q   <= '0;
      is_tick_q   <= 1'b0;
      pend_vld_q  <= '0;
      j_q         <= '0;
      k_q         <= '0;
      hold_vld_q  <= 1'b0;
      res_vld_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (tnes_pkg::cfg_idx_e'(cfg_index_i))
          tnes_pkg::CFG_CYCLE_LEN: cycle_len_q <= cfg_data_i[tnes_pkg::CYCLE_W-1:0];
          tnes_pkg::CFG_TICK_STEP: tick_step_q <= cfg_data_i[tnes_pkg::STEP_W-1:0];
          default: ;
        endcase
      end

      if (cmd_i.accept) begin
        j_q <= '0;
        k_q <= '0;
        unique case (tnes_pkg::op_e'(op_i))
          tnes_pkg::OP_LOAD: begin
            if (load_we) back_cnt_q <= back_cnt_q + CW'(1);
          end
          tnes_pkg::OP_SWAP: begin
            bank_sel_q  <= ~bank_sel_q;
            front_cnt_q <= back_cnt_q;
            back_cnt_q  <= '0;
            next_idx_q  <= '0;
          end
          tnes_pkg::OP_TICK: begin
            elapsed_q <= el_next;
            is_tick_q <= 1'b1;
          end
          tnes_pkg::OP_FLUSH: is_tick_q <= 1'b0;
          default: ;
        endcase
      end

      if (cmd_i.scan_ev && due) next_idx_q <= next_idx_q + CW'(1);
      if (alloc) pend_vld_q[free_idx] <= 1'b1;
      if (cmd_i.rank_step) j_q <= j_q + SW'(1);
      if (cmd_i.emit && hit_any) k_q <= k_q + KW'(1);

      if (cmd_i.finish) begin
        pend_vld_q <= pend_vld_q & ~elig;
        if (is_tick_q && wrap) begin
          front_cnt_q <= '0;
          next_idx_q  <= '0;
          elapsed_q   <= '0;
        end
      end

      // hold one result back so the final one can carry the last flag
      if (gen_vld) begin
        res_vld_q  <= hold_vld_q;
        hold_vld_q <= 1'b1;
      end else if (cmd_i.finish) begin
        res_vld_q  <= hold_vld_q;
        hold_vld_q <= 1'b0;
      end else begin
        res_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (alloc) begin
      pend_val_q[free_idx] <= rd_val_q;
      pend_rem_q[free_idx] <= $signed(RW'(rd_len_q));
    end
    if (cmd_i.finish && is_tick_q) begin
      for (int i = 0; i < PENDING_SLOTS; i++) begin
        if (pend_vld_q[i] && !elig[i]) begin
          pend_rem_q[i] <= pend_rem_q[i] - $signed(RW'(tick_step_q));
        end
      end
    end
    if (cmd_i.accept) begin
      for (int i = 0; i < PENDING_SLOTS; i++) rank_q[i] <= '0;
    end else if (cmd_i.rank_step) begin
      for (int i = 0; i < PENDING_SLOTS; i++) begin
        if (ahead[i]) rank_q[i] <= rank_q[i] + SW'(1);
      end
    end
    if (gen_vld) begin
      hold_val_q  <= gen_val;
      hold_on_q   <= gen_on;
      hold_lost_q <= gen_lost;
    end
    if (gen_vld || cmd_i.finish) begin
      out_val_q  <= tnes_pkg::VALUE_W'(hold_val_q);
      out_on_q   <= hold_on_q;
      out_lost_q <= hold_lost_q;
      out_last_q <= cmd_i.finish;
    end
  end

  // event bank memory, registered read
  always_ff @(posedge clk_i) begin
    if (load_we) begin
      bank_start_mem[wr_addr] <= event_start_i;
      bank_len_mem[wr_addr]   <= event_length_i;
      bank_val_mem[wr_addr]   <= event_value_i[VW-1:0];
    end
    rd_start_q <= bank_start_mem[rd_addr];
    rd_len_q   <= bank_len_mem[rd_addr];
    rd_val_q   <= bank_val_mem[rd_addr];
  end

  assign result_valid_o = res_vld_q;
  assign out_value_o    = out_val_q;
  assign is_on_o        = out_on_q;
  assign off_lost_o     = out_lost_q;
  assign last_o         = out_last_q;

endmodule

/* rtl/timed_note_event_scheduler_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_note_event_scheduler_top
// One sequencer track: double-banked event list, tick-driven note on/off
// dispatch and a pending-off store with ordered release.
// ----------------------------------------------------------------------------
// Load and swap requests finish in the cycle they are taken; busy stays low.
// A tick keeps busy high while the bank memory is scanned one event per cycle
// for the events that fire, the pending slots are ranked by remaining time
// one slot per cycle, and then the offs go out one per cycle. A flush ranks
// and emits the same way with no scan. Results leave one per cycle on
// result_valid_o and cannot be held off; the final result of a request has
// last_o set and comes in the first cycle with busy low. The event banks and
// the pending slots need no clearing after reset.
module timed_note_event_scheduler_top #(
  parameter int EVENTS_PER_BANK = tnes_pkg::EVENTS_PER_BANK_DEF,
  parameter int PENDING_SLOTS   = tnes_pkg::PENDING_SLOTS_DEF,
  parameter int PAYLOAD_BITS    = tnes_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [tnes_pkg::OP_W-1:0]      op_i,
  input  logic [tnes_pkg::TIME_W-1:0]    event_start_i,
  input  logic [tnes_pkg::TIME_W-1:0]    event_length_i,
  input  logic [tnes_pkg::VALUE_W-1:0]   event_value_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tnes_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [tnes_pkg::CFG_DAT_W-1:0] cfg_data_i,
  output logic                           result_valid_o,
  output logic [tnes_pkg::VALUE_W-1:0]   out_value_o,
  output logic                           is_on_o,
  output logic                           off_lost_o,
  output logic                           last_o
);

  tnes_pkg::cmd_t cmd;
  tnes_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  tnes_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .op_i   (op_i),
    .sts_i  (sts),
    .busy   (busy),
    .cmd_o  (cmd)
  );

  tnes_datapath #(
    .EVENTS_PER_BANK (EVENTS_PER_BANK),
    .PENDING_SLOTS   (PENDING_SLOTS),
    .PAYLOAD_BITS    (PAYLOAD_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .op_i           (op_i),
    .event_start_i  (event_start_i),
    .event_length_i (event_length_i),
    .event_value_i  (event_value_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .out_value_o    (out_value_o),
    .is_on_o        (is_on_o),
    .off_lost_o     (off_lost_o),
    .last_o         (last_o)
  );

  ap_load_swap_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (op_i == tnes_pkg::OP_LOAD || op_i == tnes_pkg::OP_SWAP))
    |=> !busy)
    else $error("load or swap request left the block busy");

  ap_inner_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_o) |-> busy)
    else $error("non-final result outside a request");

  ap_last_then_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_o) |=> !result_valid_o)
    else $error("result directly after a final result");

  ap_off_never_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !is_on_o) |-> !off_lost_o)
    else $error("off result flagged as lost");

endmodule

/* bench/note_dispatch_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// note_dispatch_checker
// Watches the request, register and result channels of the note event
// scheduler. It keeps its own copy of both event banks, the pending-off
// store, elapsed time and the two registers, and works out the note-on and
// note-off results that each accepted request must produce. Each observed
// result is compared field by field with the oldest outstanding one.
// ----------------------------------------------------------------------------
module note_dispatch_checker #(
  parameter int EVENTS_PER_BANK = tnes_pkg::EVENTS_PER_BANK_DEF,
  parameter int PENDING_SLOTS   = tnes_pkg::PENDING_SLOTS_DEF,
  parameter int PAYLOAD_BITS    = tnes_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic                           busy_i,
  input  logic [tnes_pkg::OP_W-1:0]      op_i,
  input  logic [tnes_pkg::TIME_W-1:0]    event_start_i,
  input  logic [tnes_pkg::TIME_W-1:0]    event_length_i,
  input  logic [tnes_pkg::VALUE_W-1:0]   event_value_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [tnes_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [tnes_pkg::CFG_DAT_W-1:0] cfg_data_i,
  input  logic                           result_valid_i,
  input  logic [tnes_pkg::VALUE_W-1:0]   out_value_i,
  input  logic                           is_on_i,
  input  logic                           off_lost_i,
  input  logic                           last_i,
  output int                             fail_count_o,
  output int                             pending_notes_o,
  output int                             note_ons_o,
  output int                             note_offs_o,
  output int                             offs_lost_o,
  output int                             wraps_o
);
  import tnes_pkg::*;

  localparam int CNT_W     = $clog2(EVENTS_PER_BANK + 1);
  localparam int IDX_W     = (EVENTS_PER_BANK > 1) ? $clog2(EVENTS_PER_BANK) : 1;
  localparam int KEEP_BITS = (PAYLOAD_BITS < VALUE_W) ? PAYLOAD_BITS : VALUE_W;
  localparam logic [VALUE_W-1:0]   VALUE_MASK  = {VALUE_W{1'b1}} >> (VALUE_W - KEEP_BITS);
  localparam logic [ELAPSED_W:0]   ELAPSED_MAX = {1'b0, {ELAPSED_W{1'b1}}};

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               is_on;
    logic               off_lost;
    logic               last;
  } note_t;

  // registers
  logic [CYCLE_W-1:0]   cycle_len;
  logic [STEP_W-1:0]    tick_step;

  // event banks
  logic [TIME_W-1:0]    ev_start [2][EVENTS_PER_BANK];
  logic [TIME_W-1:0]    ev_len   [2][EVENTS_PER_BANK];
  logic [VALUE_W-1:0]   ev_value [2][EVENTS_PER_BANK];
  logic                 play_bank;
  logic [CNT_W-1:0]     back_n;
  logic [CNT_W-1:0]     front_n;
  logic [CNT_W-1:0]     scan_idx;
  logic [ELAPSED_W-1:0] elapsed_us;

  // pending-off store
  logic [VALUE_W-1:0]      off_value [PENDING_SLOTS];
  logic signed [REM_W-1:0] off_rem   [PENDING_SLOTS];
  logic                    off_used  [PENDING_SLOTS];
  int                      rank_slot [PENDING_SLOTS];

  note_t note_q [$];

  task automatic report_mismatch(input string msg);
    if (fail_count_o < 40) $display("[%0t] mismatch: %s", $time, msg);
    fail_count_o++;
  endtask

  task automatic push_note(input logic [VALUE_W-1:0] value, input logic on,
                           input logic lost);
    note_t n;
    n.value    = value;
    n.is_on    = on;
    n.off_lost = lost;
    n.last     = 1'b0;
    note_q.insert(note_q.size(), n);
    if (on) note_ons_o++;
    else note_offs_o++;
    if (lost) offs_lost_o++;
  endtask

  // used slots ordered by remaining time, ties by slot index
  function automatic int rank_pending();
    int n;
    int j;
    n = 0;
    for (int s = 0; s < PENDING_SLOTS; s++) begin
      if (off_used[s]) begin
        j = n;
        while (j > 0 && off_rem[rank_slot[j-1]] > off_rem[s]) begin
          rank_slot[j] = rank_slot[j-1];
          j--;
        end
        rank_slot[j] = s;
        n++;
      end
    end
    return n;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    note_t               want;
    note_t               tail;
    logic                lost;
    logic [ELAPSED_W:0]  sum;
    int                  slot;
    int                  n_before;
    int                  n_ranked;
    if (!rst_ni) begin
      cycle_len  = CYCLE_LEN_RST;
      tick_step  = TICK_STEP_RST;
      play_bank  = 1'b0;
      back_n     = '0;
      front_n    = '0;
      scan_idx   = '0;
      elapsed_us = '0;
      for (int s = 0; s < PENDING_SLOTS; s++) off_used[s] = 1'b0;
      note_q.delete();
      fail_count_o    = 0;
      pending_notes_o = 0;
      note_ons_o      = 0;
      note_offs_o     = 0;
      offs_lost_o     = 0;
      wraps_o         = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_CYCLE_LEN: cycle_len = cfg_data_i[CYCLE_W-1:0];
          CFG_TICK_STEP: tick_step = cfg_data_i[STEP_W-1:0];
          default: ;
        endcase
      end

      if (result_valid_i === 1'b1) begin
        if (note_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result, value %h on %b", out_value_i,
                                    is_on_i));
        end else begin
          want = note_q.pop_front();
          if (out_value_i !== want.value)
            report_mismatch($sformatf("value: want %h got %h", want.value, out_value_i));
          if (is_on_i !== want.is_on)
            report_mismatch($sformatf("is_on: want %b got %b (value %h)", want.is_on,
                                      is_on_i, want.value));
          if (off_lost_i !== want.off_lost)
            report_mismatch($sformatf("off_lost: want %b got %b (value %h)",
                                      want.off_lost, off_lost_i, want.value));
          if (last_i !== want.last)
            report_mismatch($sformatf("last: want %b got %b (value %h)", want.last,
                                      last_i, want.value));
        end
      end

      if (start_i && !busy_i) begin
        n_before = note_q.size();
        case (op_e'(op_i))
          OP_LOAD: begin
            // a load into a full back bank is dropped
            if (back_n < EVENTS_PER_BANK) begin
              ev_start[~play_bank][back_n[IDX_W-1:0]] = event_start_i;
              ev_len[~play_bank][back_n[IDX_W-1:0]]   = event_length_i;
              ev_value[~play_bank][back_n[IDX_W-1:0]] = event_value_i & VALUE_MASK;
              back_n++;
            end
          end
          OP_SWAP: begin
            play_bank = ~play_bank;
            front_n   = back_n;
            back_n    = '0;
            scan_idx  = '0;
          end
          OP_TICK: begin
            sum        = elapsed_us + tick_step;
            elapsed_us = (sum > ELAPSED_MAX) ? ELAPSED_MAX[ELAPSED_W-1:0]
                                             : sum[ELAPSED_W-1:0];
            // play in load order, stop at the first event not yet due
            while (scan_idx < front_n &&
                   elapsed_us >= ev_start[play_bank][scan_idx[IDX_W-1:0]]) begin
              lost = 1'b0;
              if (ev_len[play_bank][scan_idx[IDX_W-1:0]] != '0) begin
                slot = 0;
                while (slot < PENDING_SLOTS && off_used[slot]) slot++;
                if (slot < PENDING_SLOTS) begin
                  off_used[slot]  = 1'b1;
                  off_value[slot] = ev_value[play_bank][scan_idx[IDX_W-1:0]];
                  off_rem[slot]   = $signed({1'b0, ev_len[play_bank][scan_idx[IDX_W-1:0]]});
                end else begin
                  lost = 1'b1;
                end
              end
              push_note(ev_value[play_bank][scan_idx[IDX_W-1:0]], 1'b1, lost);
              scan_idx++;
            end
            n_ranked = rank_pending();
            for (int k = 0; k < n_ranked; k++) begin
              slot = rank_slot[k];
              if (off_rem[slot] > 0) begin
                off_rem[slot] = off_rem[slot] - $signed({1'b0, tick_step});
              end else begin
                push_note(off_value[slot], 1'b0, 1'b0);
                off_used[slot] = 1'b0;
              end
            end
            if (elapsed_us >= cycle_len) begin
              front_n    = '0;
              scan_idx   = '0;
              elapsed_us = '0;
              wraps_o++;
            end
          end
          default: begin
            n_ranked = rank_pending();
            for (int k = 0; k < n_ranked; k++) begin
              push_note(off_value[rank_slot[k]], 1'b0, 1'b0);
              off_used[rank_slot[k]] = 1'b0;
            end
          end
        endcase
        if (note_q.size() > n_before) begin
          tail      = note_q[note_q.size() - 1];
          tail.last = 1'b1;
          note_q[note_q.size() - 1] = tail;
        end
      end
      pending_notes_o = note_q.size();
    end
  end

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the timed note event scheduler. A short directed sequence
// walks the corner cases at reset settings; then randomized phases, each
// with its own cycle length and tick step, load sorted bars into the back
// bank, swap, tick through parts of the cycle and flush now and then, mixed
// with stray requests. Requests go out in bursts with random gaps; a
// separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
  import tnes_pkg::*;

  localparam int RANDOM_ITEMS   = 310;
  localparam int SETTLE_CYCLES  = 100;
  localparam int WATCHDOG_LIMIT = 4000;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic [OP_W-1:0]      op_i;
  logic [TIME_W-1:0]    event_start_i;
  logic [TIME_W-1:0]    event_length_i;
  logic [VALUE_W-1:0]   event_value_i;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DAT_W-1:0] cfg_data_i;
  logic                 result_valid_o;
  logic [VALUE_W-1:0]   out_value_o;
  logic                 is_on_o;
  logic                 off_lost_o;
  logic                 last_o;

  int fail_count;
  int pending_notes;
  int note_ons;
  int note_offs;
  int offs_lost;
  int wraps;

  int sent        = 0;
  int settings    = 0;
  int burst_left  = 0;
  int idle_cycles = 0;

  timed_note_event_scheduler_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .op_i           (op_i),
    .event_start_i  (event_start_i),
    .event_length_i (event_length_i),
    .event_value_i  (event_value_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .out_value_o    (out_value_o),
    .is_on_o        (is_on_o),
    .off_lost_o     (off_lost_o),
    .last_o         (last_o)
  );

  note_dispatch_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .busy_i          (busy),
    .op_i            (op_i),
    .event_start_i   (event_start_i),
    .event_length_i  (event_length_i),
    .event_value_i   (event_value_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .result_valid_i  (result_valid_o),
    .out_value_i     (out_value_o),
    .is_on_i         (is_on_o),
    .off_lost_i      (off_lost_o),
    .last_i          (last_o),
    .fail_count_o    (fail_count),
    .pending_notes_o (pending_notes),
    .note_ons_o      (note_ons),
    .note_offs_o     (note_offs),
    .offs_lost_o     (offs_lost),
    .wraps_o         (wraps)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ends the run if nothing moves on any channel for too long
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // called right after a rising edge; returns at the edge that takes the request
  task automatic send_request(input op_e op, input logic [TIME_W-1:0] ev_start,
                              input logic [TIME_W-1:0] ev_len,
                              input logic [VALUE_W-1:0] value);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    start          <= 1'b1;
    op_i           <= op;
    event_start_i  <= ev_start;
    event_length_i <= ev_len;
    event_value_i  <= value;
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    sent++;
  endtask

  // wait for every outstanding result, then let a request with no results finish
  task automatic settle();
    start <= 1'b0;
    @(negedge clk_i);
    while (pending_notes != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_config(input logic [CYCLE_W-1:0] cyc, input logic [STEP_W-1:0] step);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_CYCLE_LEN;
    cfg_data_i  <= cyc;
    @(negedge clk_i);
    while (!cfg_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    cfg_index_i <= CFG_TICK_STEP;
    cfg_data_i  <= {{(CFG_DAT_W-STEP_W){1'b0}}, step};
    @(negedge clk_i);
    while (!cfg_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    settings++;
  endtask

  // one bar: sorted loads, swap, some ticks, sometimes a flush
  task automatic play_bar(input int unsigned cyc, input int unsigned step);
    int unsigned n_ev;
    int unsigned t;
    int unsigned span;
    int unsigned len;
    int unsigned ticks;
    n_ev = ($urandom_range(0, 3) == 0) ?
           $urandom_range(EVENTS_PER_BANK_DEF - 2, EVENTS_PER_BANK_DEF + 2) :
           $urandom_range(1, 8);
    span = cyc / (n_ev + 1);
    t    = 0;
    for (int k = 0; k < n_ev; k++) begin
      t = t + $urandom_range(0, span);
      if (t > 24'hFFFFFF) t = 24'hFFFFFF;
      case ($urandom_range(0, 7))
        0:       len = 0;
        1:       len = $urandom_range(0, 24'hFFFFFF);
        default: len = step * $urandom_range(1, 6);
      endcase
      if (len > 24'hFFFFFF) len = 24'hFFFFFF;
      send_request(OP_LOAD, TIME_W'(t), TIME_W'(len), $urandom);
    end
    // loads past a full bank are dropped and do not count
    if (n_ev > EVENTS_PER_BANK_DEF) sent -= int'(n_ev) - EVENTS_PER_BANK_DEF;
    send_request(OP_SWAP, TIME_W'($urandom_range(0, 24'hFFFFFF)),
                 TIME_W'($urandom_range(0, 24'hFFFFFF)), $urandom);
    ticks = cyc / step + 2;
    if (ticks > 14) ticks = 14;
    repeat ($urandom_range(1, ticks))
      send_request(OP_TICK, TIME_W'($urandom_range(0, 24'hFFFFFF)),
                   TIME_W'($urandom_range(0, 24'hFFFFFF)), $urandom);
    if ($urandom_range(0, 3) == 0)
      send_request(OP_FLUSH, TIME_W'($urandom_range(0, 24'hFFFFFF)),
                   TIME_W'($urandom_range(0, 24'hFFFFFF)), $urandom);
  endtask

  initial begin : stimulus
    int unsigned cyc;
    int unsigned step;
    int          phase_no;
    int          phase_end;
    int          target;
    start          <= 1'b0;
    op_i           <= OP_LOAD;
    event_start_i  <= '0;
    event_length_i <= '0;
    event_value_i  <= '0;
    cfg_valid_i    <= 1'b0;
    cfg_index_i    <= CFG_CYCLE_LEN;
    cfg_data_i     <= '0;
    rst_ni         <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part at reset settings: empty store, zero length, ties,
    // out-of-order loads, swap in mid-cycle
    send_request(OP_FLUSH, 24'h0, 24'h0, 32'h0);
    send_request(OP_TICK, 24'h0, 24'h0, 32'h0);
    send_request(OP_SWAP, 24'h0, 24'h0, 32'h0);
    send_request(OP_LOAD, 24'd0, 24'd0, 32'hFFFF_FFFF);
    send_request(OP_LOAD, 24'd0, 24'd1, 32'h0000_0000);
    send_request(OP_LOAD, 24'd300, 24'd640, 32'hA5A5_A5A5);
    send_request(OP_LOAD, 24'd1000, 24'd640, 32'h5A5A_5A5A);
    send_request(OP_LOAD, 24'd100, 24'd640, 32'h0F0F_0F0F);
    send_request(OP_LOAD, 24'hFFFFFF, 24'hFFFFFF, 32'h1234_5678);
    send_request(OP_SWAP, 24'hFFFFFF, 24'hFFFFFF, 32'hFFFF_FFFF);
    repeat (4) send_request(OP_TICK, 24'hFFFFFF, 24'hFFFFFF, 32'hFFFF_FFFF);
    send_request(OP_FLUSH, 24'h0, 24'h0, 32'h0);
    send_request(OP_LOAD, 24'd0, 24'hFFFFFF, 32'h8000_0001);
    send_request(OP_SWAP, 24'h0, 24'h0, 32'h0);
    send_request(OP_TICK, 24'h0, 24'h0, 32'h0);
    settle();
    // cycle shorter than one tick: every tick wraps
    write_config(24'd1000, 16'hFFFF);
    send_request(OP_TICK, 24'h0, 24'h0, 32'h0);
    send_request(OP_FLUSH, 24'h0, 24'h0, 32'h0);
    send_request(OP_TICK, 24'h0, 24'h0, 32'h0);

    target   = sent + RANDOM_ITEMS;
    phase_no = 0;
    while (sent < target) begin
      case (phase_no)
        0: begin cyc = 4000;       step = 320;   end
        1: begin cyc = 24'hFFFFFF; step = 16'hFFFF; end
        2: begin cyc = 1;          step = 1;     end
        3: begin cyc = 2500;       step = 1000;  end
        default: begin
          step = $urandom_range(50, 2000);
          cyc  = step * $urandom_range(2, 16) + $urandom_range(0, step);
        end
      endcase
      settle();
      write_config(CYCLE_W'(cyc), STEP_W'(step));
      phase_end = sent + $urandom_range(40, 70);
      while (sent < phase_end && sent < target) begin
        if ($urandom_range(0, 9) < 8) begin
          play_bar(cyc, step);
        end else begin
          send_request(op_e'($urandom_range(0, 3)), TIME_W'($urandom_range(0, 24'hFFFFFF)),
                       TIME_W'($urandom_range(0, 24'hFFFFFF)), $urandom);
        end
      end
      phase_no++;
    end

    settle();
    $display("covered %0d requests under %0d register settings, %0d cycle wraps",
             sent, settings, wraps);
    $display("checked %0d note-ons (%0d with off lost) and %0d note-offs",
             note_ons, offs_lost, note_offs);
    if (fail_count == 0 && pending_notes == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
